@@ sv/vmm_pkg.sv @@
package vmm_pkg;

	localparam int MaxCols = 64;
	localparam int MaxRows = 256;

	localparam int ColW    = $clog2(MaxCols);
	localparam int ColCntW = $clog2(MaxCols + 1);
	localparam int RowW    = $clog2(MaxRows);
	localparam int RowCntW = $clog2(MaxRows + 1);

	localparam int ValW     = 16;
	localparam int ProdW    = 32;
	localparam int SumW     = 40;
	localparam int NumRowsW = 9;
	localparam int NumColsW = 7;
	localparam int AddrW    = 3;
	localparam int DataW    = 32;

	localparam logic [AddrW-1:0] ADDR_NUM_ROWS = AddrW'(0);
	localparam logic [AddrW-1:0] ADDR_NUM_COLS = AddrW'(4);

	typedef enum logic [1:0] {
		ST_ACCUM,
		ST_FLUSH,
		ST_DRAIN
	} state_t;

	// Map a programmed row count onto 1..MaxRows.
	function automatic logic [RowCntW-1:0] eff_rows(input logic [NumRowsW-1:0] r);
		logic [RowCntW-1:0] res;
		if (r == '0) begin
			res = RowCntW'(1);
		end else if (32'(r) > MaxRows) begin
			res = RowCntW'(MaxRows);
		end else begin
			res = RowCntW'(r);
		end
		return res;
	endfunction

	// Map a programmed column count onto 1..MaxCols.
	function automatic logic [ColCntW-1:0] eff_cols(input logic [NumColsW-1:0] c);
		logic [ColCntW-1:0] res;
		if (c == '0) begin
			res = ColCntW'(1);
		end else if (32'(c) > MaxCols) begin
			res = ColCntW'(MaxCols);
		end else begin
			res = ColCntW'(c);
		end
		return res;
	endfunction

endpackage

@@ sv/vector_matrix_multiply_unit.sv @@
// Row vector times matrix, one matrix element per request.
//
// Input channel (in_valid/in_ready): each request carries one matrix element
// (mat_value, row-major order) and the vector element of its row (vec_value),
// both signed Q8.8. The column sums are signed Q24.16 and kept in a 64-entry
// RAM, one entry per column.
// Output channel (out_valid/out_ready): after the request that completes the
// last row, the block drains num_cols results in column order (out_value,
// out_index), with out_last high on the final one.
// Throughput: one input request per cycle while accumulating. The accepting
// edge registers the product and the RAM entry of its column; the next edge
// writes the sum back, with forwarding when the same column comes back to back.
// Input stays closed for the whole drain: a flush state, then the drain state,
// which issues a RAM read only once the previous one has landed; the first
// read follows the flush and loads the output register when it lands. No read
// is issued while the receiver holds a result back. Configuration (APB):
// num_rows at 0x0, num_cols at 0x4; a write to either restarts the run. Reset
// clears the counters and sets both sizes to 1; the RAM is not cleared since
// the first row overwrites every entry.
module vector_matrix_multiply_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [vmm_pkg::AddrW-1:0]            paddr,
	input  logic [vmm_pkg::DataW-1:0]            pwdata,
	output logic [vmm_pkg::DataW-1:0]            prdata,
	output logic                                 pready,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [vmm_pkg::ValW-1:0]      vec_value,
	input  logic signed [vmm_pkg::ValW-1:0]      mat_value,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [vmm_pkg::SumW-1:0]      out_value,
	output logic [vmm_pkg::ColW-1:0]             out_index,
	output logic                                 out_last
);
	import vmm_pkg::*;

	// Configuration registers
	logic [NumRowsW-1:0] num_rows_q;
	logic [NumColsW-1:0] num_cols_q;
	logic                cfg_we;
	logic                cfg_hit;

	// Run position and sizes
	logic [ColW-1:0]    col_q;
	logic [RowW-1:0]    row_q;
	logic [ColCntW-1:0] cols_eff;
	logic [RowCntW-1:0] rows_eff;
	logic               col_last;
	logic               row_last;
	logic               in_acc;

	// Accumulate stage
	logic                    v_s1;
	logic [ColW-1:0]         col_s1;
	logic                    first_s1;
	logic signed [ProdW-1:0] prod_s1;
	logic                    fwd_s1;
	logic signed [SumW-1:0]  fwd_val_s1;
	logic signed [SumW-1:0]  base_s1;
	logic signed [SumW-1:0]  sum_s1;

	// RAM
	logic [ColW-1:0] ram_raddr;
	logic [SumW-1:0] ram_rdata;

	// Drain
	state_t             state_q;
	state_t             state_d;
	logic               rd_issue;
	logic [ColCntW-1:0] rd_idx_q;
	logic               rd_pend_q;
	logic [ColW-1:0]    rd_idx_s1;

	// Output register
	logic                   out_valid_q;
	logic signed [SumW-1:0] out_value_q;
	logic [ColW-1:0]        out_index_q;
	logic                   out_last_q;

	// APB: zero wait states; writes to unmapped addresses are dropped.
	assign pready  = 1'b1;
	assign cfg_we  = psel && penable && pwrite;
	assign cfg_hit = cfg_we && (paddr == ADDR_NUM_ROWS || paddr == ADDR_NUM_COLS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_rows_q <= NumRowsW'(1);
			num_cols_q <= NumColsW'(1);
		end else if (cfg_we) begin
			unique case (paddr)
				ADDR_NUM_ROWS: num_rows_q <= pwdata[NumRowsW-1:0];
				ADDR_NUM_COLS: num_cols_q <= pwdata[NumColsW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr)
			ADDR_NUM_ROWS: prdata = DataW'(num_rows_q);
			ADDR_NUM_COLS: prdata = DataW'(num_cols_q);
			default:       prdata = '0;
		endcase
	end

	assign cols_eff = eff_cols(num_cols_q);
	assign rows_eff = eff_rows(num_rows_q);
	assign col_last = ColCntW'(col_q) == cols_eff - ColCntW'(1);
	assign row_last = RowCntW'(row_q) == rows_eff - RowCntW'(1);
	assign in_acc   = in_valid && in_ready;

	// Advance the element position; a configuration write restarts the run.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_hit) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_acc) begin
			if (col_last) begin
				col_q <= '0;
				row_q <= row_last ? '0 : row_q + RowW'(1);
			end else begin
				col_q <= col_q + ColW'(1);
			end
		end
	end

	// Register the product while the RAM entry of its column is read.
	// Flag forwarding when the previous request writes the same column now.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			fwd_s1 <= 1'b0;
		end else begin
			v_s1   <= in_acc;
			fwd_s1 <= in_acc && v_s1 && (col_s1 == col_q);
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			col_s1     <= col_q;
			first_s1   <= (row_q == '0);
			prod_s1    <= vec_value * mat_value;
			fwd_val_s1 <= sum_s1;
		end
	end

	// First row overwrites the stale sum; later rows add to it.
	assign base_s1 = fwd_s1 ? fwd_val_s1 : $signed(ram_rdata);
	assign sum_s1  = first_s1 ? SumW'(prod_s1) : base_s1 + SumW'(prod_s1);

	assign ram_raddr = (state_q == ST_DRAIN) ? rd_idx_q[ColW-1:0] : col_q;

	vmm_ram #(
		.Width(SumW),
		.Depth(MaxCols)
	) u_sums (
		.clk  (clk),
		.we   (v_s1),
		.waddr(col_s1),
		.wdata(sum_s1),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Drain sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACCUM;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		rd_issue = 1'b0;
		unique case (state_q)
			ST_ACCUM: begin
				in_ready = 1'b1;
				if (in_acc && col_last && row_last) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				// Let the last write land before the first read.
				state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				rd_issue = (rd_idx_q != cols_eff) && !rd_pend_q
					&& (!out_valid_q || out_ready);
				if (rd_idx_q == cols_eff && !rd_pend_q) begin
					state_d = ST_ACCUM;
				end
			end
			default: state_d = ST_ACCUM;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q  <= '0;
			rd_pend_q <= 1'b0;
		end else begin
			rd_pend_q <= rd_issue;
			if (state_q == ST_FLUSH) begin
				rd_idx_q <= '0;
			end else if (rd_issue) begin
				rd_idx_q <= rd_idx_q + ColCntW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_issue) begin
			rd_idx_s1 <= rd_idx_q[ColW-1:0];
		end
	end

	// Output register: load landed read data, drop on acceptance.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rd_pend_q) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_pend_q) begin
			out_value_q <= $signed(ram_rdata);
			out_index_q <= rd_idx_s1;
			out_last_q  <= ColCntW'(rd_idx_s1) == cols_eff - ColCntW'(1);
		end
	end

	assign out_valid = out_valid_q;
	assign out_value = out_value_q;
	assign out_index = out_index_q;
	assign out_last  = out_last_q;

`ifndef NO_ASSERTIONS
	// No accumulate write may be in flight while the drain reads the RAM.
	a_no_write_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DRAIN |-> !v_s1)
		else $error("accumulate write during drain");

	// Landed read data must never overwrite a result still waiting.
	a_out_free_on_land: assert property (@(posedge clk) disable iff (!arst_n)
		rd_pend_q |-> !out_valid_q)
		else $error("drain read lands on a full output register");

	// Forwarding only applies to a request in the accumulate stage.
	a_fwd_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		fwd_s1 |-> v_s1)
		else $error("forward flag without a request");

	// A drain read lands in the cycle after issue and loads the output after that.
	a_issue_then_load: assert property (@(posedge clk) disable iff (!arst_n)
		rd_issue |=> rd_pend_q ##1 out_valid_q)
		else $error("drain read did not reach the output register");
`endif

endmodule

@@ sv/vmm_ram.sv @@
module vmm_ram #(
	parameter int Width = 40,
	parameter int Depth = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem [Depth];

	// Read returns the old entry when the same address is written in that cycle.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
